[src/spq_pkg.sv]
// shared types and codes for the sorted priority queue
// no dependencies; imported by spq_cell, sorted_priority_queue_core and the testbench
`default_nettype none

package spq_pkg;

    localparam int ValueW = 32;
    localparam int PrioW  = 16;

    typedef enum logic [0:0] {
        REQ_PUSH = 1'b0,
        REQ_POP  = 1'b1
    } t_req;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } t_status;

    typedef struct packed {
        logic signed [ValueW-1:0] value;
        logic        [PrioW-1:0]  prio;
    } t_entry;

    // per-cycle command broadcast to every cell
    typedef struct packed {
        logic push;
        logic pop;
    } t_cell_ctl;

endpackage

`default_nettype wire

[src/spq_cell.sv]
// one slot of the sorted chain: holds an entry, shifts toward its neighbors
// depends on spq_pkg
`default_nettype none

module spq_cell
    import spq_pkg::*;
(
    input  wire              i_clk,
    input  wire t_cell_ctl   i_ctl,
    input  wire              i_occ,
    input  wire t_entry      i_new,
    input  wire t_entry      i_prev,
    input  wire              i_prev_keep,
    input  wire t_entry      i_next,
    output t_entry           o_entry,
    output logic             o_keep
);

    t_entry r_entry;
    t_entry n_entry;

    // an occupied slot with equal or higher priority stays ahead of the new entry
    assign o_keep  = i_occ && (r_entry.prio >= i_new.prio);
    assign o_entry = r_entry;

    always_comb begin
        n_entry = r_entry;
        if (i_ctl.push && !o_keep) begin
            n_entry = i_prev_keep ? i_new : i_prev;
        end else if (i_ctl.pop) begin
            n_entry = i_next;
        end
    end

    always_ff @(posedge i_clk) begin
        r_entry <= n_entry;
    end

endmodule

`default_nettype wire

[src/sorted_priority_queue_core.sv]
// sorted priority queue built as a chain of spq_cell slots, head in slot 0
// depends on spq_pkg and spq_cell
//
//  channel | valid   | stall   | payload
//  --------+---------+---------+---------------------------------------------
//  request | i_valid | o_stall | i_req_type, i_element_value, i_priority_req
//  result  | o_valid | i_stall | o_popped_*, o_head_*, o_entry_count, o_status
//
// one request per cycle unless stalled; every slot compares against the new
// entry in parallel and all slots shift in the same edge, so the result follows
// in the next cycle. reset (i_rst_n low, synchronous) empties the queue; slot
// contents are not cleared. a stalled result holds the chain and stalls the
// request side; a waiting result that is taken lets a new request in that cycle.
`default_nettype none

module sorted_priority_queue_core
    import spq_pkg::*;
#(
    parameter int DEPTH = 16
) (
    input  wire                i_clk,
    input  wire                i_rst_n,
    input  wire                i_valid,
    output logic               o_stall,
    input  wire  [0:0]         i_req_type,
    input  wire  signed [31:0] i_element_value,
    input  wire  [15:0]        i_priority_req,
    output logic               o_valid,
    input  wire                i_stall,
    output logic signed [31:0] o_popped_value,
    output logic               o_popped_valid,
    output logic signed [31:0] o_head_value,
    output logic [15:0]        o_head_priority,
    output logic               o_head_valid,
    output logic [4:0]         o_entry_count,
    output logic [1:0]         o_status
);

    localparam int CW = $clog2(DEPTH + 1);

    t_entry    cells [DEPTH];
    logic      keep  [DEPTH];
    t_entry    new_entry;
    t_cell_ctl ctl;
    logic      accept;
    logic      full;
    logic      empty;
    logic      is_pop;

    logic [CW-1:0]     r_count;
    logic [CW-1:0]     n_count;
    logic              r_out_valid;
    logic              n_out_valid;
    logic signed [31:0] r_popped_value;
    logic signed [31:0] n_popped_value;
    logic              r_popped_valid;
    logic              n_popped_valid;
    t_status           r_status;
    t_status           n_status;
    logic [CW+4:0]     count_ext;

    assign o_stall   = r_out_valid && i_stall;
    assign accept    = i_valid && !o_stall;
    assign full      = (r_count == CW'(DEPTH));
    assign empty     = (r_count == '0);
    assign is_pop    = (t_req'(i_req_type) == REQ_POP);
    assign new_entry = '{value: i_element_value, prio: i_priority_req};

    assign ctl.push = accept && !is_pop && !full;
    assign ctl.pop  = accept && is_pop && !empty;

    genvar gi;
    generate
        for (gi = 0; gi < DEPTH; gi++) begin : g_cell
            localparam logic [CW-1:0] Idx = CW'(gi);
            t_entry prev_e;
            t_entry next_e;
            logic   prev_k;
            if (gi == 0) begin : g_first
                assign prev_e = new_entry;
                assign prev_k = 1'b1;
            end else begin : g_mid
                assign prev_e = cells[gi-1];
                assign prev_k = keep[gi-1];
            end
            if (gi == DEPTH - 1) begin : g_last
                assign next_e = new_entry;
            end else begin : g_inner
                assign next_e = cells[gi+1];
            end
            spq_cell u_cell (
                .i_clk       (i_clk),
                .i_ctl       (ctl),
                .i_occ       (Idx < r_count),
                .i_new       (new_entry),
                .i_prev      (prev_e),
                .i_prev_keep (prev_k),
                .i_next      (next_e),
                .o_entry     (cells[gi]),
                .o_keep      (keep[gi])
            );
        end
    endgenerate

    always_comb begin
        n_count        = r_count;
        n_out_valid    = r_out_valid && i_stall;
        n_popped_value = r_popped_value;
        n_popped_valid = r_popped_valid;
        n_status       = r_status;
        if (accept) begin
            n_out_valid    = 1'b1;
            n_popped_value = '0;
            n_popped_valid = 1'b0;
            n_status       = ST_OK;
            if (is_pop) begin
                if (empty) begin
                    n_status = ST_EMPTY;
                end else begin
                    n_popped_value = cells[0].value;
                    n_popped_valid = 1'b1;
                    n_count        = r_count - CW'(1);
                end
            end else begin
                if (full) begin
                    n_status = ST_FULL;
                end else begin
                    n_count = r_count + CW'(1);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
        r_popped_value <= n_popped_value;
        r_popped_valid <= n_popped_valid;
        r_status       <= n_status;
    end

    assign count_ext       = {5'd0, r_count};
    assign o_valid         = r_out_valid;
    assign o_popped_value  = r_popped_value;
    assign o_popped_valid  = r_popped_valid;
    assign o_head_valid    = !empty;
    assign o_head_value    = empty ? 32'sd0 : cells[0].value;
    assign o_head_priority = empty ? 16'd0 : cells[0].prio;
    assign o_entry_count   = count_ext[4:0];
    assign o_status        = r_status;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(DEPTH))
        else $error("entry count above depth");

    a_head_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count >= CW'(2)) |-> (cells[0].prio >= cells[1].prio))
        else $error("head slot out of priority order");

    a_push_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ctl.push |=> (r_count == $past(r_count) + CW'(1)))
        else $error("push did not grow the queue");

    a_full_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_status == ST_FULL) |-> (r_count == CW'(DEPTH)))
        else $error("full status with room left");

    a_pop_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ctl.pop |=> (r_popped_valid && r_status == ST_OK))
        else $error("pop transfer without removed value");

endmodule

`default_nettype wire

[tb/sv/sorted_priority_queue_core_test.sv]
// self-checking testbench for sorted_priority_queue_core: push/pop traffic
// against a behavioral copy of the sorted queue. depends on spq_pkg and the core
`timescale 1ns / 100ps

module sorted_priority_queue_core_test
    import spq_pkg::*;
();

    localparam int DEPTH       = 16;
    localparam int CYCLE_LIMIT = 400000;
    localparam int MAX_REPORTS = 10;
    localparam int DRAIN_WAIT  = 10;

    typedef struct {
        logic signed [31:0] popped_value;
        logic               popped_valid;
        logic signed [31:0] head_value;
        logic [15:0]        head_priority;
        logic               head_valid;
        logic [4:0]         entry_count;
        t_status            status;
    } t_q_result;

    logic               i_clk           = 1'b0;
    logic               i_rst_n         = 1'b0;
    logic               i_valid         = 1'b0;
    logic               o_stall;
    logic [0:0]         i_req_type      = REQ_PUSH;
    logic signed [31:0] i_element_value = '0;
    logic [15:0]        i_priority_req  = '0;
    logic               o_valid;
    logic               i_stall         = 1'b0;
    logic signed [31:0] o_popped_value;
    logic               o_popped_valid;
    logic signed [31:0] o_head_value;
    logic [15:0]        o_head_priority;
    logic               o_head_valid;
    logic [4:0]         o_entry_count;
    logic [1:0]         o_status;

    // behavioral copy of the queue, slot 0 is the head
    t_entry      model_slots [DEPTH];
    int unsigned model_fill = 0;
    t_q_result   pending_results [$];

    int idle_pct       = 21;
    int stall_pct      = 21;
    int hold_left      = 0;
    int cycle_count    = 0;
    int mismatch_count = 0;
    int checked_count  = 0;
    int push_ok_count  = 0;
    int push_full_count = 0;
    int pop_ok_count   = 0;
    int pop_empty_count = 0;

    sorted_priority_queue_core #(.DEPTH(DEPTH)) i_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_stall         (o_stall),
        .i_req_type      (i_req_type),
        .i_element_value (i_element_value),
        .i_priority_req  (i_priority_req),
        .o_valid         (o_valid),
        .i_stall         (i_stall),
        .o_popped_value  (o_popped_value),
        .o_popped_valid  (o_popped_valid),
        .o_head_value    (o_head_value),
        .o_head_priority (o_head_priority),
        .o_head_valid    (o_head_valid),
        .o_entry_count   (o_entry_count),
        .o_status        (o_status)
    );

    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_count, pending_results.size());
            $display("sorted_priority_queue_core regression: fail");
            $finish;
        end
    end

    // result side backpressure; a hold-off keeps stall high while hold_left counts down
    always @(negedge i_clk) begin
        if (hold_left > 0) begin
            i_stall <= 1'b1;
            hold_left--;
        end else begin
            i_stall <= ($urandom_range(0, 99) < stall_pct);
        end
    end

    function automatic t_q_result apply_queue_request(t_req req, logic signed [31:0] val,
                                                      logic [15:0] pri);
        t_q_result res;
        int        pos;
        res.popped_value = '0;
        res.popped_valid = 1'b0;
        res.status       = ST_OK;
        if (req == REQ_PUSH) begin
            if (model_fill >= DEPTH) begin
                res.status = ST_FULL;
                push_full_count++;
            end else begin
                // new entry goes behind every entry of equal or higher priority
                pos = model_fill;
                while (pos > 0 && model_slots[pos-1].prio < pri) begin
                    model_slots[pos] = model_slots[pos-1];
                    pos--;
                end
                model_slots[pos].value = val;
                model_slots[pos].prio  = pri;
                model_fill++;
                push_ok_count++;
            end
        end else begin
            if (model_fill == 0) begin
                res.status = ST_EMPTY;
                pop_empty_count++;
            end else begin
                res.popped_value = model_slots[0].value;
                res.popped_valid = 1'b1;
                for (pos = 1; pos < model_fill; pos++)
                    model_slots[pos-1] = model_slots[pos];
                model_fill--;
                pop_ok_count++;
            end
        end
        res.head_valid    = (model_fill > 0);
        res.head_value    = (model_fill > 0) ? model_slots[0].value : '0;
        res.head_priority = (model_fill > 0) ? model_slots[0].prio : '0;
        res.entry_count   = model_fill[4:0];
        return res;
    endfunction

    always @(posedge i_clk) begin : check_results
        t_q_result want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (pending_results.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= MAX_REPORTS)
                    $display("unexpected result at cycle %0d", cycle_count);
            end else begin
                want = pending_results.pop_front();
                checked_count++;
                if (o_popped_value !== want.popped_value ||
                    o_popped_valid !== want.popped_valid ||
                    o_head_value !== want.head_value ||
                    o_head_priority !== want.head_priority ||
                    o_head_valid !== want.head_valid ||
                    o_entry_count !== want.entry_count ||
                    o_status !== want.status) begin
                    mismatch_count++;
                    if (mismatch_count <= MAX_REPORTS) begin
                        $display("mismatch on result %0d at cycle %0d", checked_count,
                                 cycle_count);
                        $display("  expected popped %0d/%0b head %0d/%h/%0b count %0d st %0d",
                                 want.popped_value, want.popped_valid, want.head_value,
                                 want.head_priority, want.head_valid, want.entry_count,
                                 want.status);
                        $display("  actual   popped %0d/%0b head %0d/%h/%0b count %0d st %0d",
                                 o_popped_value, o_popped_valid, o_head_value,
                                 o_head_priority, o_head_valid, o_entry_count, o_status);
                    end
                end
            end
        end
    end

    // offers one request from a falling edge, holds it until the transfer
    task automatic send_request(t_req req, logic signed [31:0] val, logic [15:0] pri);
        t_q_result expected;
        @(negedge i_clk);
        while ($urandom_range(0, 99) < idle_pct) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_valid         <= 1'b1;
        i_req_type      <= req;
        i_element_value <= val;
        i_priority_req  <= pri;
        do @(posedge i_clk); while (o_stall);
        expected = apply_queue_request(req, val, pri);
        pending_results.insert(pending_results.size(), expected);
    endtask

    task automatic go_idle();
        @(negedge i_clk);
        i_valid <= 1'b0;
    endtask

    task automatic wait_results_done();
        while (pending_results.size() != 0) @(posedge i_clk);
    endtask

    function automatic logic [15:0] pick_priority();
        int sel;
        sel = $urandom_range(0, 9);
        if (sel == 0)
            return 16'h0000;
        else if (sel == 1)
            return 16'hFFFF;
        else if (sel < 6)
            return 16'($urandom_range(0, 3));   // narrow range for lots of ties
        else
            return 16'($urandom);
    endfunction

    function automatic logic signed [31:0] pick_value();
        int sel;
        sel = $urandom_range(0, 19);
        if (sel == 0)
            return 32'sh8000_0000;
        else if (sel == 1)
            return 32'sh7FFF_FFFF;
        else
            return 32'($urandom);
    endfunction

    task automatic test_empty_and_extremes();
        send_request(REQ_POP, 32'sh1234_5678, 16'hFFFF);
        send_request(REQ_PUSH, 32'sh8000_0000, 16'h0000);
        send_request(REQ_PUSH, 32'sh7FFF_FFFF, 16'hFFFF);
        send_request(REQ_POP, 32'sh0, 16'h0);
        send_request(REQ_POP, -32'sd1, 16'hFFFF);
        send_request(REQ_POP, 32'sh0, 16'h0);
    endtask

    // equal priorities must leave in arrival order; a full queue refuses pushes
    task automatic test_fill_and_overflow();
        int k;
        for (k = 0; k < DEPTH; k++)
            send_request(REQ_PUSH, 32'(k * 17 - 100), 16'((k % 4) * 16'h4000));
        send_request(REQ_PUSH, -32'sd7, 16'hFFFF);
        for (k = 0; k < 4; k++)
            send_request(REQ_POP, 32'($urandom), 16'($urandom));
    endtask

    task automatic test_random_traffic(int count, int push_pct);
        int   k;
        t_req req;
        for (k = 0; k < count; k++) begin
            req = ($urandom_range(0, 99) < push_pct) ? REQ_PUSH : REQ_POP;
            send_request(req, pick_value(), pick_priority());
        end
    endtask

    task automatic test_no_idle_stretch();
        idle_pct  = 0;
        stall_pct = 0;
        test_random_traffic(200, 55);
        idle_pct  = 21;
        stall_pct = 21;
    endtask

    // receiver holds off while requests keep coming, so the request side stalls
    task automatic test_result_hold_off();
        hold_left = 300;
        test_random_traffic(40, 60);
    endtask

    task automatic test_sender_pause();
        go_idle();
        wait_results_done();
        test_random_traffic(30, 50);
    endtask

    initial begin
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_empty_and_extremes();
        test_fill_and_overflow();
        test_random_traffic(300, 70);
        test_random_traffic(250, 30);
        test_no_idle_stretch();
        test_result_hold_off();
        test_random_traffic(300, 60);
        test_sender_pause();
        test_random_traffic(250, 40);
        test_random_traffic(200, 50);

        go_idle();
        wait_results_done();
        repeat (DRAIN_WAIT) @(posedge i_clk);

        if (pending_results.size() != 0) begin
            mismatch_count++;
            $display("%0d expected results never arrived", pending_results.size());
        end
        $display("checked %0d results: %0d pushes, %0d refused when full",
                 checked_count, push_ok_count, push_full_count);
        $display("  %0d pops, %0d on empty queue, %0d mismatches",
                 pop_ok_count, pop_empty_count, mismatch_count);
        if (mismatch_count == 0) begin
            $display("sorted_priority_queue_core regression: pass");
        end else begin
            $display("sorted_priority_queue_core regression: fail");
        end
        $finish;
    end

endmodule

[sim.f]
src/spq_pkg.sv
src/spq_cell.sv
src/sorted_priority_queue_core.sv
tb/sv/sorted_priority_queue_core_test.sv
